FILE: rtl/fptw_pkg.sv
// ============================================================================
// fptw_pkg - four-level page table walker package
// Entry layout, operation and status codes, and stream widths shared by the
// walker and its checker.
// ============================================================================
package fptw_pkg;

	// Address and table geometry
	localparam int VA_W          = 48;
	localparam int OFF_W         = 12;
	localparam int IDX_W         = 9;
	localparam int TABLE_ENTRIES = 512;
	localparam int FRAME_W       = 36;

	// Stored entry: frame number above five flag bits (P, RW, US, PWT, PCD)
	localparam int FLAG_W  = 5;
	localparam int ENTRY_W = FRAME_W + FLAG_W;
	localparam logic [FLAG_W-1:0] LINK_FLAGS = 5'b00011;

	// Operation codes
	localparam logic [1:0] OP_MAP       = 2'd0;
	localparam logic [1:0] OP_UNMAP     = 2'd1;
	localparam logic [1:0] OP_TRANSLATE = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOMAP     = 2'd1;
	localparam logic [1:0] ST_ELSEWHERE = 2'd2;
	localparam logic [1:0] ST_EXHAUSTED = 2'd3;

	// Stream widths
	localparam int OP_W       = 2;
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 104;
	localparam int CFG_W      = FRAME_W;

endpackage

FILE: rtl/four_level_page_table_walker.sv
// ============================================================================
// four_level_page_table_walker - x86-64 style four-level page table walker
// Keeps the page tables in an on-chip pool of table frames and serves map,
// unmap and translate requests one at a time.
// ============================================================================
// Each table created by a map adds a clear pass over its 512 entries and a
// read of the new table's entry before the walk goes on. Undefined
// operations skip the walk and go straight to the result.
// Throughput: one request at a time; the table RAM's single read port sets
// the pace, one dependent entry read per level.
// Reset: asynchronous; afterwards the root table is cleared, during which no
// input is accepted. Configuration writes are always taken.
// ============================================================================
module four_level_page_table_walker #(
	parameter int TABLE_FRAMES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,

	// Request stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata, from bit 0 up: virt_addr[47:0], phys_addr[47:0], writable,
	// user_access, write_through, cache_disable, zero padding
	input  logic [fptw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// tuser: operation[1:0]
	input  logic [fptw_pkg::OP_W-1:0]         s_axis_tuser,

	// Result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata, from bit 0 up: status[1:0], translated_addr[47:0],
	// tlb_invalidate, invalidate_addr[47:0], zero padding
	output logic [fptw_pkg::OUT_DATA_W-1:0]   m_axis_tdata,

	// Configuration: pool_base_frame
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fptw_pkg::CFG_W-1:0]        cfg_data
);

	import fptw_pkg::*;

	localparam int SLOT_W = $clog2(TABLE_FRAMES);
	localparam int CNT_W  = $clog2(TABLE_FRAMES + 1);
	localparam int RAM_AW = SLOT_W + IDX_W;
	localparam int DEPTH  = TABLE_FRAMES * TABLE_ENTRIES;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CHK,
		S_CLR,
		S_LEAF,
		S_RESP
	} state_t;

	// Picks the nine index bits of the given level out of a virtual address.
	function automatic logic [IDX_W-1:0] idx_at(input logic [VA_W-1:0] va,
	                                            input logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		case (lvl)
			2'd3:    idx = va[47:39];
			2'd2:    idx = va[38:30];
			2'd1:    idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

	state_t                  state_q;
	logic                    init_q;
	logic [IDX_W-1:0]        clr_cnt_q;
	logic [1:0]              level_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [CNT_W-1:0]        nff_q;
	logic [FRAME_W-1:0]      base_q;
	logic [RAM_AW-1:0]       rd_addr_q;

	// Latched request
	logic [OP_W-1:0]         op_q;
	logic [VA_W-1:0]         va_q;
	logic [FRAME_W-1:0]      frame_q;
	logic [3:0]              flags_q;

	// Result being built, and the output register
	logic [1:0]              res_status_q;
	logic [VA_W-1:0]         res_taddr_q;
	logic                    res_inv_q;
	logic [VA_W-1:0]         res_iaddr_q;
	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;

	// Table RAM ports
	logic                    ram_re;
	logic [RAM_AW-1:0]       ram_raddr;
	logic                    ram_we;
	logic [RAM_AW-1:0]       ram_waddr;
	logic [ENTRY_W-1:0]      ram_wdata;
	logic [ENTRY_W-1:0]      ram_rdata;

	// Entry decode and the shared frame adder
	logic                    ent_p;
	logic [FRAME_W-1:0]      ent_frame;
	logic [FRAME_W-1:0]      nff_ext;
	logic [FRAME_W-1:0]      add_a;
	logic [FRAME_W-1:0]      add_b;
	logic [FRAME_W-1:0]      add_ci;
	logic [FRAME_W-1:0]      add_sum;
	logic                    rel_ok;
	logic                    pool_full;
	logic [IDX_W-1:0]        idx_cur;
	logic [IDX_W-1:0]        idx_dn;
	logic                    leaf_clash;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	fptw_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_table_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// The one adder serves two purposes. On a present link it forms the
	// frame's offset from the pool base (frame - base), which must fall below
	// the allocation mark to be a valid slot. On a missing level it forms the
	// physical frame of the slot about to be allocated (base + next free).
	always_comb begin
		ent_p      = ram_rdata[0];
		ent_frame  = ram_rdata[ENTRY_W-1:FLAG_W];
		nff_ext    = FRAME_W'(nff_q);
		add_a      = ent_p ? ent_frame : base_q;
		add_b      = ent_p ? ~base_q : nff_ext;
		add_ci     = FRAME_W'(ent_p);
		add_sum    = add_a + add_b + add_ci;
		rel_ok     = (add_sum < nff_ext);
		pool_full  = (nff_q == CNT_W'(TABLE_FRAMES));
		idx_cur    = idx_at(va_q, level_q);
		idx_dn     = idx_at(va_q, level_q - 2'd1);
		leaf_clash = ent_p && (ent_frame != frame_q);

		ram_re    = 1'b0;
		ram_raddr = {slot_q, idx_cur};
		ram_we    = 1'b0;
		ram_waddr = rd_addr_q;
		ram_wdata = '0;

		unique case (state_q)
			S_RD: begin
				ram_re = 1'b1;
			end
			S_CHK: begin
				if (ent_p) begin
					// Follow the link straight into the next level's read.
					if (rel_ok) begin
						ram_re    = 1'b1;
						ram_raddr = {add_sum[SLOT_W-1:0], idx_dn};
					end
				end else if (op_q == OP_MAP && !pool_full) begin
					// Link the freshly allocated table into its parent.
					ram_we    = 1'b1;
					ram_wdata = {add_sum, LINK_FLAGS};
				end
			end
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = {slot_q, clr_cnt_q};
			end
			S_LEAF: begin
				if (op_q == OP_MAP && !leaf_clash) begin
					ram_we    = 1'b1;
					ram_wdata = {frame_q, flags_q, 1'b1};
				end else if (op_q == OP_UNMAP && ent_p) begin
					ram_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// Reset starts with a clear pass over the root table (slot 0).
			state_q      <= S_CLR;
			init_q       <= 1'b1;
			clr_cnt_q    <= '0;
			level_q      <= '0;
			slot_q       <= '0;
			nff_q        <= CNT_W'(1);
			base_q       <= '0;
			rd_addr_q    <= '0;
			op_q         <= '0;
			va_q         <= '0;
			frame_q      <= '0;
			flags_q      <= '0;
			res_status_q <= ST_NOMAP;
			res_taddr_q  <= '0;
			res_inv_q    <= 1'b0;
			res_iaddr_q  <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			if (cfg_valid) begin
				base_q <= cfg_data;
			end
			if (ram_re) begin
				rd_addr_q <= ram_raddr;
			end
			// The output register loads a new result or empties on a transfer.
			if (state_q == S_RESP && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q         <= s_axis_tuser;
						va_q         <= s_axis_tdata[47:0];
						frame_q      <= s_axis_tdata[95:60];
						flags_q      <= s_axis_tdata[99:96];
						level_q      <= 2'd3;
						slot_q       <= '0;
						res_status_q <= ST_NOMAP;
						res_taddr_q  <= '0;
						res_inv_q    <= 1'b0;
						res_iaddr_q  <= '0;
						if (s_axis_tuser == OP_MAP || s_axis_tuser == OP_UNMAP ||
						    s_axis_tuser == OP_TRANSLATE) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_RD: begin
					state_q <= (level_q == 2'd0) ? S_LEAF : S_CHK;
				end
				S_CHK: begin
					if (ent_p) begin
						if (rel_ok) begin
							slot_q  <= add_sum[SLOT_W-1:0];
							level_q <= level_q - 2'd1;
							state_q <= (level_q == 2'd1) ? S_LEAF : S_CHK;
						end else begin
							// Link points outside the allocated pool.
							res_status_q <= ST_NOMAP;
							state_q      <= S_RESP;
						end
					end else if (op_q != OP_MAP) begin
						res_status_q <= ST_NOMAP;
						state_q      <= S_RESP;
					end else if (pool_full) begin
						res_status_q <= ST_EXHAUSTED;
						state_q      <= S_RESP;
					end else begin
						nff_q     <= nff_q + CNT_W'(1);
						slot_q    <= nff_q[SLOT_W-1:0];
						level_q   <= level_q - 2'd1;
						clr_cnt_q <= '0;
						state_q   <= S_CLR;
					end
				end
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + IDX_W'(1);
					if (clr_cnt_q == '1) begin
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_RD;
					end
				end
				S_LEAF: begin
					state_q <= S_RESP;
					if (op_q == OP_MAP) begin
						if (leaf_clash) begin
							res_status_q <= ST_ELSEWHERE;
						end else begin
							res_status_q <= ST_OK;
							res_inv_q    <= 1'b1;
							res_iaddr_q  <= {va_q[VA_W-1:OFF_W], {OFF_W{1'b0}}};
						end
					end else if (ent_p) begin
						res_status_q <= ST_OK;
						if (op_q == OP_UNMAP) begin
							res_inv_q   <= 1'b1;
							res_iaddr_q <= {va_q[VA_W-1:OFF_W], {OFF_W{1'b0}}};
						end else begin
							res_taddr_q <= {ent_frame, va_q[OFF_W-1:0]};
						end
					end else begin
						res_status_q <= ST_NOMAP;
					end
				end
				S_RESP: begin
					// The output register frees the walker as soon as it can hold this result:
					// when it is empty or its previous result is being taken.
					if (!out_valid_q || m_axis_tready) begin
						out_data_q  <= {5'b0, res_iaddr_q, res_inv_q, res_taddr_q,
						                res_status_q};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/fptw_ram.sv
// ============================================================================
// fptw_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
module fptw_ram #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/fptw_checker.sv
// ============================================================================
// fptw_checker - port-level checks for the page table walker
// Watches the result stream for combinations the walker must never produce.
// ============================================================================
module fptw_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [fptw_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

	import fptw_pkg::*;

	// A stalled result stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Invalidation is only requested by a successful map or unmap.
	a_inv_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[50] |-> m_axis_tdata[1:0] == ST_OK &&
		m_axis_tdata[49:2] == 48'd0)
		else $error("invalidation without a successful map or unmap");

	// A fault never carries a translated address.
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[49:2] == 48'd0)
		else $error("faulting result carries an address");

	// The invalidation address is page aligned, and zero when not requested.
	a_inv_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[62:51] == 12'd0 &&
		(m_axis_tdata[50] || m_axis_tdata[98:51] == 48'd0))
		else $error("bad invalidation address");

endmodule

bind four_level_page_table_walker fptw_checker u_fptw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

FILE: sim/testbench.sv
// ============================================================================
// testbench - self-checking bench for the four-level page table walker
// Drives map, unmap and translate requests into the walker, keeps its own
// copy of the table pool, the bump allocator and the pool base register, and
// compares every result transfer field by field against that copy.
// A short directed table comes first, then three phases of random traffic
// under different pool base settings and idling patterns.
// ============================================================================
`timescale 1ns / 100ps

module testbench;
	import fptw_pkg::*;

	// Pool size handed to the walker; the bench's own copy uses the same figure
	localparam int POOL_FRAMES = 64;

	// Operation code the walker does not define; it must answer "not mapped"
	localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

	// Pool base settings: both ends of the legal range and a shift by one frame,
	// which makes every existing link land one table off
	localparam logic [FRAME_W-1:0] BASE_LOW     = 36'h0;
	localparam logic [FRAME_W-1:0] BASE_HIGH    = 36'hFFFFFFFC0;
	localparam logic [FRAME_W-1:0] BASE_SHIFTED = 36'h1;

	// Scrambles a page number into a frame number, so that repeated maps of one
	// page often ask for the same frame and remaps succeed
	localparam logic [FRAME_W-1:0] PA_SCRAMBLE = 36'h5A3C961E7;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [VA_W-1:0]  va;
		logic [VA_W-1:0]  pa;
		logic             writable;
		logic             user_access;
		logic             write_through;
		logic             cache_disable;
	} request_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [VA_W-1:0]  translated_addr;
		logic             invalidate;
		logic [VA_W-1:0]  invalidate_addr;
	} result_t;

	// One line of the directed table: either a pool base write or a request,
	// issued reps times with the top-level index stepped by one each time
	typedef struct packed {
		logic                is_cfg;
		logic [FRAME_W-1:0]  cfg_value;
		request_t            rq;
		logic [7:0]          reps;
		logic                typed;
		result_t             want;
	} stim_row_t;

	// ------------------------------------------------------------------------
	// Clock, reset and the walker's ports
	// ------------------------------------------------------------------------
	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;

	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	// tdata, from bit 0 up: virt_addr, phys_addr, writable, user_access,
	// write_through, cache_disable, zero padding
	logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
	// tuser: operation
	logic [OP_W-1:0]         s_axis_tuser = OP_TRANSLATE;

	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	// tdata, from bit 0 up: status, translated_addr, tlb_invalidate,
	// invalidate_addr, zero padding
	logic [OUT_DATA_W-1:0]   m_axis_tdata;

	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_W-1:0]        cfg_data = '0;

	four_level_page_table_walker #(
		.TABLE_FRAMES(POOL_FRAMES)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// 10 ns period: high for 5 ns, low for 5 ns
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// The bench's copy of the walker's state
	// ------------------------------------------------------------------------
	// Each stored entry is {frame number, PCD, PWT, US, RW, P}, so bit 0 is the
	// present bit and bits 40..5 the frame, as in the walker's own layout.
	logic [ENTRY_W-1:0]  page_tables [POOL_FRAMES*TABLE_ENTRIES];
	int                  next_table_slot;
	logic [FRAME_W-1:0]  pool_base;

	// Results still owed by the walker, oldest first
	result_t             pending_results[$];
	// Upper 27 address bits of pages that have been mapped, so that random
	// traffic mostly lands in tables that actually exist
	logic [26:0]         mapped_regions[$];
	stim_row_t           directed_rows[$];

	int                  error_count = 0;
	int                  tx_idle_pct = 11;
	int                  rx_idle_pct = 77;
	result_t             observed;

	// Walks the three upper levels for va. With create set, missing tables are
	// taken from the bump allocator, cleared and linked as present and
	// writable. A present link whose frame is not an allocated slot of the
	// pool (possible once the base has moved) ends the walk as "not mapped".
	function automatic logic [1:0] find_leaf(input logic [VA_W-1:0] va, input bit create,
			output int leaf);
		int                  slot;
		int                  lvl;
		int                  pos;
		int                  k;
		logic [IDX_W-1:0]    idx;
		logic [FRAME_W-1:0]  rel;
		slot = 0;
		leaf = 0;
		for (lvl = 3; lvl > 0; lvl--) begin
			idx = va[OFF_W + lvl*IDX_W +: IDX_W];
			pos = slot*TABLE_ENTRIES + idx;
			if (page_tables[pos][0]) begin
				rel = page_tables[pos][ENTRY_W-1:FLAG_W] - pool_base;
				if (rel >= next_table_slot || rel >= POOL_FRAMES)
					return ST_NOMAP;
				slot = int'(rel);
			end else begin
				if (!create)
					return ST_NOMAP;
				// Tables linked on the way down stay in place when the pool runs dry
				if (next_table_slot >= POOL_FRAMES)
					return ST_EXHAUSTED;
				for (k = 0; k < TABLE_ENTRIES; k++)
					page_tables[next_table_slot*TABLE_ENTRIES + k] = '0;
				page_tables[pos] = {pool_base + FRAME_W'(next_table_slot), LINK_FLAGS};
				slot = next_table_slot;
				next_table_slot++;
			end
		end
		leaf = slot*TABLE_ENTRIES + va[OFF_W +: IDX_W];
		return ST_OK;
	endfunction

	// Applies one accepted request to the bench's tables and returns the result
	// the walker owes for it.
	function automatic result_t apply_request(input request_t rq);
		result_t             res;
		logic [1:0]          st;
		int                  leaf;
		logic [VA_W-1:0]     vpage;
		logic [FRAME_W-1:0]  frame;
		res = '0;
		res.status = ST_NOMAP;
		vpage = {rq.va[VA_W-1:OFF_W], {OFF_W{1'b0}}};
		case (rq.op)
			OP_MAP: begin
				frame = rq.pa[VA_W-1:OFF_W];
				st = find_leaf(vpage, 1'b1, leaf);
				if (st != ST_OK) begin
					res.status = st;
				end else if (page_tables[leaf][0]
						&& page_tables[leaf][ENTRY_W-1:FLAG_W] != frame) begin
					res.status = ST_ELSEWHERE;
				end else begin
					// Same frame again is a legal remap: new flags, new invalidation
					page_tables[leaf] = {frame, rq.cache_disable, rq.write_through,
						rq.user_access, rq.writable, 1'b1};
					res.status = ST_OK;
					res.invalidate = 1'b1;
					res.invalidate_addr = vpage;
				end
			end
			OP_UNMAP: begin
				st = find_leaf(vpage, 1'b0, leaf);
				if (st == ST_OK && page_tables[leaf][0]) begin
					page_tables[leaf] = '0;
					res.status = ST_OK;
					res.invalidate = 1'b1;
					res.invalidate_addr = vpage;
				end
			end
			OP_TRANSLATE: begin
				st = find_leaf(rq.va, 1'b0, leaf);
				if (st == ST_OK && page_tables[leaf][0]) begin
					res.status = ST_OK;
					res.translated_addr = {page_tables[leaf][ENTRY_W-1:FLAG_W],
						rq.va[OFF_W-1:0]};
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------
	// The receiver drops tready at random; the share of idle cycles is set per
	// phase and is zero in the last one.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

	task automatic compare_field(input string name, input logic [VA_W-1:0] want,
			input logic [VA_W-1:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Every result transfer is matched against the oldest pending expectation.
	// The values read here are the ones held before the edge, so the check does
	// not depend on the order in which processes wake at the edge.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			observed.status          = m_axis_tdata[1:0];
			observed.translated_addr = m_axis_tdata[49:2];
			observed.invalidate      = m_axis_tdata[50];
			observed.invalidate_addr = m_axis_tdata[98:51];
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: result transfer with nothing expected, expected none, actual %h",
					$time, observed);
			end else begin
				compare_field("status", VA_W'(pending_results[0].status), VA_W'(observed.status));
				compare_field("translated_addr", pending_results[0].translated_addr,
					observed.translated_addr);
				compare_field("tlb_invalidate", VA_W'(pending_results[0].invalidate),
					VA_W'(observed.invalidate));
				compare_field("invalidate_addr", pending_results[0].invalidate_addr,
					observed.invalidate_addr);
				void'(pending_results.pop_front());
			end
		end
	end

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------
	// Called at a falling edge. Leaves tvalid high afterwards, so that the next
	// request can follow back to back; whoever stops sending lowers it.
	task automatic push_request(input request_t rq, input logic typed, input result_t want);
		result_t  predicted;
		bit       seen;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0000, rq.cache_disable, rq.write_through, rq.user_access,
			rq.writable, rq.pa, rq.va};
		s_axis_tuser  <= rq.op;
		do @(posedge clk); while (!s_axis_tready);
		// The transfer has happened at this edge; the bench's state moves on even
		// where the directed table already states the answer.
		predicted = apply_request(rq);
		pending_results.push_back(typed ? want : predicted);
		if (rq.op == OP_MAP) begin
			seen = 1'b0;
			foreach (mapped_regions[i])
				if (mapped_regions[i] == rq.va[VA_W-1:21])
					seen = 1'b1;
			if (!seen && mapped_regions.size() < 48)
				mapped_regions.push_back(rq.va[VA_W-1:21]);
		end
		@(negedge clk);
	endtask

	// Stops sending and waits at falling edges until every owed result is in.
	// It always waits at a falling edge before it returns, so tvalid is never lowered and raised in one step.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	// Pool base writes only happen with the walker idle. Every request yields a
	// result, so an empty expectation queue means nothing is in flight.
	task automatic write_pool_base(input logic [FRAME_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		pool_base = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random request: most addresses fall in regions that have been mapped, with
	// a leaf index near either end of its table or anywhere; one in ten is an
	// address with every bit random. Half the physical addresses follow from the
	// page, so remaps to the same frame come up often.
	function automatic request_t random_request();
		request_t          rq;
		int                pick;
		logic [IDX_W-1:0]  leaf;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			rq.op = OP_MAP;
		else if (pick < 60)
			rq.op = OP_UNMAP;
		else if (pick < 95)
			rq.op = OP_TRANSLATE;
		else
			rq.op = OP_UNDEFINED;
		rq.va = {16'($urandom), $urandom};
		if (mapped_regions.size() != 0 && $urandom_range(0, 9) != 0) begin
			leaf = IDX_W'($urandom_range(0, 7));
			if ($urandom_range(0, 1) == 1)
				leaf = leaf | 9'h1F8;
			if ($urandom_range(0, 3) == 0)
				leaf = IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
			rq.va = {mapped_regions[$urandom_range(0, mapped_regions.size() - 1)], leaf,
				rq.va[OFF_W-1:0]};
		end
		rq.pa = {16'($urandom), $urandom};
		if ($urandom_range(0, 1) == 1)
			rq.pa[VA_W-1:OFF_W] = rq.va[VA_W-1:OFF_W] ^ PA_SCRAMBLE;
		{rq.writable, rq.user_access, rq.write_through, rq.cache_disable} = 4'($urandom);
		return rq;
	endfunction

	// One phase of random traffic under one pool base and one idling pattern.
	// Now and then the sender holds off until every result has come back.
	task automatic run_random_traffic(input int count, input int tx_pct, input int rx_pct,
			input logic [FRAME_W-1:0] base);
		int  n;
		write_pool_base(base);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) == 0)
				wait_idle();
			push_request(random_request(), 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------------
	function automatic result_t outcome(input logic [1:0] status,
			input logic [VA_W-1:0] taddr, input logic inv, input logic [VA_W-1:0] iaddr);
		result_t  res;
		res.status          = status;
		res.translated_addr = taddr;
		res.invalidate      = inv;
		res.invalidate_addr = iaddr;
		return res;
	endfunction

	// flags, from the top bit down: cache_disable, write_through, user_access,
	// writable
	task automatic add_row(input logic [OP_W-1:0] op, input logic [VA_W-1:0] va,
			input logic [VA_W-1:0] pa, input logic [3:0] flags, input int reps,
			input logic typed, input result_t want);
		stim_row_t  row;
		row = '0;
		row.rq.op = op;
		row.rq.va = va;
		row.rq.pa = pa;
		{row.rq.cache_disable, row.rq.write_through, row.rq.user_access,
			row.rq.writable} = flags;
		row.reps  = 8'(reps);
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endtask

	task automatic add_cfg_row(input logic [FRAME_W-1:0] value);
		stim_row_t  row;
		row = '0;
		row.is_cfg    = 1'b1;
		row.cfg_value = value;
		directed_rows.push_back(row);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int        k;
		request_t  rq;

		foreach (page_tables[i])
			page_tables[i] = '0;
		next_table_slot = 1;
		pool_base = BASE_LOW;

		// Empty tables: nothing to find, nothing to remove, unknown code ignored
		add_row(OP_TRANSLATE, 48'h0000_0000_0000, 48'h0, 4'b0000, 1, 1'b1,
			outcome(ST_NOMAP, 48'h0, 1'b0, 48'h0));
		add_row(OP_UNMAP, 48'h0000_0000_1000, 48'h0, 4'b0000, 1, 1'b1,
			outcome(ST_NOMAP, 48'h0, 1'b0, 48'h0));
		add_row(OP_UNDEFINED, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'b1111, 1, 1'b1,
			outcome(ST_NOMAP, 48'h0, 1'b0, 48'h0));
		// Lowest and highest page, each building a full chain of three tables
		add_row(OP_MAP, 48'h0000_0000_0000, 48'h0000_0000_0000, 4'b0000, 1, 1'b1,
			outcome(ST_OK, 48'h0, 1'b1, 48'h0));
		add_row(OP_TRANSLATE, 48'h0000_0000_0FFF, 48'h0, 4'b0000, 1, 1'b1,
			outcome(ST_OK, 48'h0000_0000_0FFF, 1'b0, 48'h0));
		add_row(OP_MAP, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'b1111, 1, 1'b1,
			outcome(ST_OK, 48'h0, 1'b1, 48'hFFFF_FFFF_F000));
		add_row(OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, 48'h0, 4'b0000, 1, 1'b1,
			outcome(ST_OK, 48'hFFFF_FFFF_FFFF, 1'b0, 48'h0));
		// Present leaf with another frame is refused; the same frame is a remap
		add_row(OP_MAP, 48'hFFFF_FFFF_F000, 48'h1234_5678_9000, 4'b1111, 1, 1'b1,
			outcome(ST_ELSEWHERE, 48'h0, 1'b0, 48'h0));
		add_row(OP_MAP, 48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_F123, 4'b0101, 1, 1'b1,
			outcome(ST_OK, 48'h0, 1'b1, 48'hFFFF_FFFF_F000));
		add_row(OP_TRANSLATE, 48'hFFFF_FFFF_F800, 48'h0, 4'b0000, 1, 1'b0, '0);
		// Unmap rounds down to the page, and a second unmap finds nothing
		add_row(OP_UNMAP, 48'hFFFF_FFFF_F7FF, 48'h0, 4'b0000, 1, 1'b1,
			outcome(ST_OK, 48'h0, 1'b1, 48'hFFFF_FFFF_F000));
		add_row(OP_UNMAP, 48'hFFFF_FFFF_F000, 48'h0, 4'b0000, 1, 1'b1,
			outcome(ST_NOMAP, 48'h0, 1'b0, 48'h0));
		add_row(OP_TRANSLATE, 48'hFFFF_FFFF_F000, 48'h0, 4'b0000, 1, 1'b1,
			outcome(ST_NOMAP, 48'h0, 1'b0, 48'h0));
		// A single new bottom table under an existing chain
		add_row(OP_MAP, 48'h0000_0020_1000, 48'h0ABC_DEF5_A000, 4'b1010, 1, 1'b0, '0);
		add_row(OP_TRANSLATE, 48'h0000_0020_1ABC, 48'h0, 4'b0000, 1, 1'b0, '0);
		add_row(OP_UNMAP, 48'h8000_0000_0000, 48'h0, 4'b0000, 1, 1'b1,
			outcome(ST_NOMAP, 48'h0, 1'b0, 48'h0));
		// Fresh top-level indices until the pool runs out part way down a chain;
		// the tables linked before that stay in place
		add_row(OP_MAP, 48'h0100_0000_3000, 48'h0000_7000_0000, 4'b0011, 19, 1'b0, '0);
		add_row(OP_MAP, 48'h0A80_0000_0000, 48'h0000_0000_1000, 4'b0001, 1, 1'b1,
			outcome(ST_EXHAUSTED, 48'h0, 1'b0, 48'h0));
		// Base moved to the top of its range: every existing link now points
		// outside the pool and ends the walk as not mapped
		add_cfg_row(BASE_HIGH);
		add_row(OP_TRANSLATE, 48'h0000_0000_0000, 48'h0, 4'b0000, 1, 1'b1,
			outcome(ST_NOMAP, 48'h0, 1'b0, 48'h0));
		add_row(OP_MAP, 48'h0000_0000_1000, 48'h0000_0000_5000, 4'b0001, 1, 1'b1,
			outcome(ST_NOMAP, 48'h0, 1'b0, 48'h0));
		add_row(OP_UNMAP, 48'h0000_0000_0000, 48'h0, 4'b0000, 1, 1'b1,
			outcome(ST_NOMAP, 48'h0, 1'b0, 48'h0));
		// Back at the bottom of the range the old tables are reachable again
		add_cfg_row(BASE_LOW);
		add_row(OP_TRANSLATE, 48'h0000_0000_0ABC, 48'h0, 4'b0000, 1, 1'b1,
			outcome(ST_OK, 48'h0000_0000_0ABC, 1'b0, 48'h0));

		// Reset is released at a falling edge. The walker then
		// clears its root table and holds tready low until it is done.
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				write_pool_base(directed_rows[i].cfg_value);
			end else begin
				for (k = 0; k < directed_rows[i].reps; k++) begin
					rq = directed_rows[i].rq;
					rq.va = rq.va + (48'(k) << 39);
					rq.pa = rq.pa + (48'(k) << OFF_W);
					push_request(rq, directed_rows[i].typed, directed_rows[i].want);
				end
			end
		end

		// Sender idles a little while the receiver stalls a lot, then the other
		// way round under a base shifted by one frame, then full speed both ways
		run_random_traffic(550, 11, 77, BASE_LOW);
		run_random_traffic(250, 77, 11, BASE_SHIFTED);
		run_random_traffic(500, 0, 0, BASE_LOW);

		// Drain, then give the walker time to show any stray result transfer
		wait_idle();
		repeat (20) @(negedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// Hard stop: far beyond the slowest correct run, table clears included
	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
